FILE: rtl/lpss_pkg.sv
package lpss_pkg;

   localparam int MaxSteps = 8;
   localparam int StepWidth = 3;
   localparam int LenWidth = 4;
   localparam int DurWidth = 16;
   localparam int TimeWidth = 17;
   localparam int CycleWidth = 8;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexWidth = 3;

   localparam logic KindTick = 1'b0;
   localparam logic KindRestart = 1'b1;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_STEP_COUNT     = 3'd0,
      CSR_CYCLE_LIMIT    = 3'd1,
      CSR_EXPONENTIAL    = 3'd2,
      CSR_DURATIONS_LOW  = 3'd3,
      CSR_DURATIONS_HIGH = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LOAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                kind;
      logic [DurWidth-1:0] increment;
   } req_word_type;

   typedef struct packed {
      logic [StepWidth-1:0] step_index;
      logic                 refresh;
      logic                 done_res;
   } rsp_word_type;

   typedef struct packed {
      logic                  go;
      logic                  wrap;
      logic [DurWidth-1:0]   dur;
      logic [TimeWidth-1:0]  diff;
      logic [StepWidth-1:0]  next_step;
   } step_status_type;

   // Clamp step count into 1..MaxSteps.
   function automatic logic [LenWidth-1:0] eff_len(input logic [LenWidth-1:0] count);
      logic [LenWidth-1:0] n;
      n = count;
      if (n == '0) begin
         n = LenWidth'(1);
      end
      if (n > LenWidth'(MaxSteps)) begin
         n = LenWidth'(MaxSteps);
      end
      return n;
   endfunction

endpackage

FILE: rtl/led_pattern_step_sequencer_top.sv
// A tick while the cycle limit holds goes from accept straight to the result; otherwise
// the run consumes 0..8 steps, the step that reaches the cycle limit included.
// Input stalls from accept until the result is loaded, so a new word is taken only after
// the last one's result; one compare-subtract unit checks one step duration per cycle.
// Reset (synchronous): step, time and cycle count clear; step_count = 1, other
// registers 0; no word pending.
module led_pattern_step_sequencer_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lpss_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lpss_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_we,
   input  logic [lpss_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [lpss_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import lpss_pkg::*;

   logic [LenWidth-1:0]     step_count_ff, step_count_in;
   logic [CycleWidth-1:0]   pass_limit_ff, pass_limit_in;
   logic                    exponential_ff, exponential_in;
   logic [CsrDataWidth-1:0] durations_low_ff, durations_low_in;
   logic [CsrDataWidth-1:0] durations_high_ff, durations_high_in;

   logic [LenWidth-1:0]     len;
   step_status_type         status;
   logic [StepWidth-1:0]    step;
   logic [TimeWidth-1:0]    elapsed;
   logic [LenWidth-1:0]     taken;

   always_comb begin
      step_count_in = step_count_ff;
      pass_limit_in = pass_limit_ff;
      exponential_in = exponential_ff;
      durations_low_in = durations_low_ff;
      durations_high_in = durations_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEP_COUNT:     step_count_in = csr_wdata[LenWidth-1:0];
            CSR_CYCLE_LIMIT:    pass_limit_in = csr_wdata[CycleWidth-1:0];
            CSR_EXPONENTIAL:    exponential_in = csr_wdata[0];
            CSR_DURATIONS_LOW:  durations_low_in = csr_wdata;
            CSR_DURATIONS_HIGH: durations_high_in = csr_wdata;
            default: begin
               // drop writes to unknown indexes
               step_count_in = step_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= LenWidth'(1);
         pass_limit_ff <= '0;
         exponential_ff <= 1'b0;
         durations_low_ff <= '0;
         durations_high_ff <= '0;
      end else begin
         step_count_ff <= step_count_in;
         pass_limit_ff <= pass_limit_in;
         exponential_ff <= exponential_in;
         durations_low_ff <= durations_low_in;
         durations_high_ff <= durations_high_in;
      end
   end

   assign len = eff_len(step_count_ff);

   lpss_step_unit u_step_unit (
      .durations_low  (durations_low_ff),
      .durations_high (durations_high_ff),
      .step           (step),
      .elapsed        (elapsed),
      .taken          (taken),
      .len            (len),
      .status         (status)
   );

   lpss_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .len              (len),
      .pass_limit       (pass_limit_ff),
      .exponential_mode (exponential_ff),
      .status           (status),
      .step             (step),
      .elapsed          (elapsed),
      .taken            (taken)
   );

endmodule

FILE: rtl/lpss_step_unit.sv
module lpss_step_unit (
   input  logic [lpss_pkg::CsrDataWidth-1:0] durations_low,
   input  logic [lpss_pkg::CsrDataWidth-1:0] durations_high,
   input  logic [lpss_pkg::StepWidth-1:0]    step,
   input  logic [lpss_pkg::TimeWidth-1:0]    elapsed,
   input  logic [lpss_pkg::LenWidth-1:0]     taken,
   input  logic [lpss_pkg::LenWidth-1:0]     len,
   output lpss_pkg::step_status_type         status
);
   import lpss_pkg::*;

   logic [CsrDataWidth-1:0] word;
   logic [DurWidth-1:0]     dur;
   logic [TimeWidth-1:0]    dur_ext;
   logic [LenWidth-1:0]     next;

   always_comb begin
      word = step[2] ? durations_high : durations_low;
      dur = word[{step[1:0], 4'b0000} +: DurWidth];
      dur_ext = {1'b0, dur};
      next = {1'b0, step} + LenWidth'(1);
      status.dur = dur;
      status.diff = elapsed - dur_ext;
      status.go = (elapsed >= dur_ext) && (taken < len);
      status.wrap = next >= len;
      status.next_step = next[StepWidth-1:0];
   end

endmodule

FILE: rtl/lpss_ctrl.sv
module lpss_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lpss_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lpss_pkg::rsp_word_type             rsp_word,
   input  logic [lpss_pkg::LenWidth-1:0]      len,
   input  logic [lpss_pkg::CycleWidth-1:0]    pass_limit,
   input  logic                               exponential_mode,
   input  lpss_pkg::step_status_type          status,
   output logic [lpss_pkg::StepWidth-1:0]     step,
   output logic [lpss_pkg::TimeWidth-1:0]     elapsed,
   output logic [lpss_pkg::LenWidth-1:0]      taken
);
   import lpss_pkg::*;

   state_type              state_ff, state_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic [TimeWidth-1:0]   elapsed_ff, elapsed_in;
   logic [CycleWidth-1:0]  cycles_ff, cycles_in;
   logic [LenWidth-1:0]    taken_ff, taken_in;
   logic [StepWidth-1:0]   prev_ff, prev_in;
   logic                   refresh_ff, refresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   limit_on;
   logic                   held;
   logic                   start_held;
   logic [CycleWidth-1:0]  cycles_inc;
   logic                   limit_hit;
   logic                   out_free;

   always_comb begin
      limit_on = pass_limit != '0;
      held = limit_on && (cycles_ff >= pass_limit);
      start_held = (req_word.kind == KindTick) && held;
      cycles_inc = cycles_ff + CycleWidth'(1);
      limit_hit = status.go && status.wrap && limit_on && (cycles_inc >= pass_limit);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = start_held ? ST_OUT : ST_RUN;
            end
         end
         ST_RUN: begin
            if (limit_hit) begin
               state_in = ST_LOAD;
            end else if (!status.go) begin
               state_in = ST_OUT;
            end
         end
         ST_LOAD: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      step_in = step_ff;
      elapsed_in = elapsed_ff;
      cycles_in = cycles_ff;
      taken_in = taken_ff;
      prev_in = prev_ff;
      refresh_in = refresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               taken_in = '0;
               if (req_word.kind == KindRestart) begin
                  step_in = '0;
                  elapsed_in = '0;
                  cycles_in = '0;
                  prev_in = '0;
                  refresh_in = 1'b1;
               end else begin
                  prev_in = step_ff;
                  refresh_in = 1'b0;
                  if (!held) begin
                     elapsed_in = elapsed_ff + {1'b0, req_word.increment};
                  end
               end
            end
         end
         ST_RUN: begin
            if (status.go) begin
               elapsed_in = status.diff;
               taken_in = taken_ff + LenWidth'(1);
               if (status.wrap) begin
                  if (limit_on) begin
                     cycles_in = cycles_inc;
                  end
                  if (limit_hit) begin
                     // jump to last step and hold; duration loads next cycle
                     step_in = StepWidth'(len - LenWidth'(1));
                     refresh_in = 1'b1;
                  end else begin
                     step_in = '0;
                  end
               end else begin
                  step_in = status.next_step;
               end
            end else begin
               if (taken_ff >= len) begin
                  elapsed_in = '0;
               end
               refresh_in = refresh_ff || (step_ff != prev_ff) || exponential_mode;
            end
         end
         ST_LOAD: begin
            elapsed_in = {1'b0, status.dur};
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.step_index = step_ff;
               rsp_word_in.refresh = refresh_ff;
               rsp_word_in.done_res = held;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         elapsed_ff <= '0;
         cycles_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         elapsed_ff <= elapsed_in;
         cycles_ff <= cycles_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_ff <= taken_in;
      prev_ff <= prev_in;
      refresh_ff <= refresh_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;
   assign step = step_ff;
   assign elapsed = elapsed_ff;
   assign taken = taken_ff;

endmodule

FILE: tb/led_pattern_step_sequencer_checker.sv
module led_pattern_step_sequencer_checker
   import lpss_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  req_word_type                 req_word,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  rsp_word_type                 rsp_word,
   input  logic                         csr_we,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [CsrDataWidth-1:0]      csr_wdata,
   input  logic                         end_of_test,
   output int                           failures,
   output int                           pending
);

   localparam int PrintLimit = 100;

   // Shadow registers
   logic [LenWidth-1:0]     cfg_count;
   logic [CycleWidth-1:0]   cfg_limit;
   logic                    cfg_expo;
   logic [CsrDataWidth-1:0] cfg_dur_lo;
   logic [CsrDataWidth-1:0] cfg_dur_hi;

   // Sequencer state as it should be
   logic [StepWidth-1:0]    seq_step;
   logic [TimeWidth-1:0]    seq_time;
   logic [CycleWidth-1:0]   seq_cycles;

   rsp_word_type            expected_rsps[$];
   int                      error_total = 0;
   logic                    leftover_reported = 1'b0;

   task automatic report_mismatch(input string field, input int got, input int want);
      if (error_total < PrintLimit) begin
         $display("%0t: %s: got %0d, want %0d", $realtime, field, got, want);
      end
      error_total++;
   endtask

   function automatic logic [DurWidth-1:0] step_duration(input logic [StepWidth-1:0] idx);
      logic [CsrDataWidth-1:0] bank;
      bank = idx[2] ? cfg_dur_hi : cfg_dur_lo;
      return bank[DurWidth*idx[1:0] +: DurWidth];
   endfunction

   function automatic logic limit_held();
      return cfg_limit != '0 && seq_cycles >= cfg_limit;
   endfunction

   function automatic rsp_word_type advance_pattern(input req_word_type w);
      rsp_word_type r;
      int           len;
      int           prev_step;
      int           cur;
      int           taken;
      int unsigned  el;
      int unsigned  dur;
      logic         fresh;
      logic         hit_limit;
      len = (cfg_count == '0) ? 1 : ((cfg_count > MaxSteps) ? MaxSteps : int'(cfg_count));
      fresh = 1'b0;
      hit_limit = 1'b0;
      el = seq_time + w.increment;
      if (w.kind == KindRestart) begin
         seq_step = '0;
         seq_time = '0;
         seq_cycles = '0;
         fresh = 1'b1;
         el = 0;
      end
      if (!limit_held()) begin
         prev_step = seq_step;
         cur = seq_step;
         taken = 0;
         dur = step_duration(cur[2:0]);
         while (!hit_limit && el >= dur && taken < len) begin
            el -= dur;
            cur++;
            taken++;
            if (cur >= len) begin
               if (cfg_limit != '0) begin
                  seq_cycles = seq_cycles + 1'b1;
                  // limit reached: park on the last step with its time used up
                  if (seq_cycles >= cfg_limit) begin
                     seq_step = StepWidth'(len - 1);
                     seq_time = step_duration(StepWidth'(len - 1));
                     fresh = 1'b1;
                     hit_limit = 1'b1;
                  end
               end
               cur = 0;
            end
            dur = step_duration(cur[2:0]);
         end
         if (!hit_limit) begin
            if (taken >= len) begin
               el = 0;
            end
            seq_step = cur[2:0];
            seq_time = el[TimeWidth-1:0];
            if (cur != prev_step || cfg_expo) begin
               fresh = 1'b1;
            end
         end
      end
      r.step_index = seq_step;
      r.refresh = fresh;
      r.done_res = limit_held();
      return r;
   endfunction

   task automatic check_word(input rsp_word_type got);
      rsp_word_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch("word with none expected, step_index", got.step_index, 0);
         return;
      end
      want = expected_rsps.pop_front();
      if (got.step_index !== want.step_index) begin
         report_mismatch("step_index", got.step_index, want.step_index);
      end
      if (got.refresh !== want.refresh) begin
         report_mismatch("refresh", got.refresh, want.refresh);
      end
      if (got.done_res !== want.done_res) begin
         report_mismatch("done_res", got.done_res, want.done_res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_count = LenWidth'(1);
         cfg_limit = '0;
         cfg_expo = 1'b0;
         cfg_dur_lo = '0;
         cfg_dur_hi = '0;
         seq_step = '0;
         seq_time = '0;
         seq_cycles = '0;
         expected_rsps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_COUNT:     cfg_count = csr_wdata[LenWidth-1:0];
               CSR_CYCLE_LIMIT:    cfg_limit = csr_wdata[CycleWidth-1:0];
               CSR_EXPONENTIAL:    cfg_expo = csr_wdata[0];
               CSR_DURATIONS_LOW:  cfg_dur_lo = csr_wdata;
               CSR_DURATIONS_HIGH: cfg_dur_hi = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            check_word(rsp_word);
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(advance_pattern(req_word));
         end
         if (end_of_test && !leftover_reported && expected_rsps.size() != 0) begin
            report_mismatch("words never returned", 0, expected_rsps.size());
            leftover_reported = 1'b1;
         end
      end
      pending <= expected_rsps.size();
      failures <= error_total;
   end

endmodule

FILE: tb/led_pattern_step_sequencer_top_test.sv
module led_pattern_step_sequencer_top_test;
   import lpss_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrSpareFirst = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CsrSpareLast = 3'd7;
   localparam int LongHold = 300;
   localparam int WatchdogLimit = 4000;
   localparam int RandomPhases = 9;
   localparam int WordsPerPhase = 55;
   localparam int PressurePhase = 4;
   localparam int DrainCycles = 20;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_word_type               req_word = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_we = 1'b0;
   logic [CsrIndexWidth-1:0]   csr_index = '0;
   logic [CsrDataWidth-1:0]    csr_wdata = '0;
   logic                       end_of_test = 1'b0;
   int                         failures;
   int                         pending;
   int                         idle_cycles = 0;
   int                         burst_left = 0;
   int                         hold_requests = 0;
   int                         holds_served = 0;
   int                         hold_left = 0;
   int                         stall_run = 0;

   led_pattern_step_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   led_pattern_step_sequencer_checker step_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .end_of_test (end_of_test),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver: random stall runs, quiet stretches, and a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LongHold;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_run = 60;
         rsp_stall <= 1'b0;
      end else begin
         stall_run = $urandom_range(0, 12);
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [DurWidth-1:0] pick_duration();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         7:       return DurWidth'($urandom_range(21, 65534));
         8:       return DurWidth'($urandom);
         9:       return '1;
         default: return DurWidth'($urandom_range(1, 20));
      endcase
   endfunction

   function automatic logic [DurWidth-1:0] pick_increment();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return DurWidth'($urandom);
         default: return DurWidth'($urandom_range(1, 30));
      endcase
   endfunction

   function automatic logic [LenWidth-1:0] pick_count();
      if ($urandom_range(0, 9) < 7) begin
         return LenWidth'($urandom_range(1, MaxSteps));
      end
      return LenWidth'($urandom);
   endfunction

   function automatic logic [CycleWidth-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0, 1:    return '0;
         2, 3:    return CycleWidth'($urandom_range(1, 6));
         default: return CycleWidth'($urandom);
      endcase
   endfunction

   // Offer one word; keep valid up within a burst, drop it for a gap after
   task automatic send_word(input logic kind, input logic [DurWidth-1:0] inc);
      req_word_type w;
      int           gap;
      w.kind = kind;
      w.increment = inc;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? 50 : $urandom_range(0, 15);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_pattern(input logic [LenWidth-1:0] count,
                                  input logic [CycleWidth-1:0] limit,
                                  input logic expo,
                                  input logic [CsrDataWidth-1:0] lo,
                                  input logic [CsrDataWidth-1:0] hi);
      logic [CsrDataWidth-1:0] noise;
      noise = {$urandom, $urandom};
      write_register(CsrIndexWidth'($urandom_range(CsrSpareFirst, CsrSpareLast)), noise);
      write_register(CSR_STEP_COUNT, {noise[CsrDataWidth-1:LenWidth], count});
      write_register(CSR_CYCLE_LIMIT, {noise[CsrDataWidth-1:CycleWidth], limit});
      write_register(CSR_EXPONENTIAL, {noise[CsrDataWidth-1:1], expo});
      write_register(CSR_DURATIONS_LOW, lo);
      write_register(CSR_DURATIONS_HIGH, hi);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [CsrDataWidth-1:0] lo;
      logic [CsrDataWidth-1:0] hi;
      int                      p;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all durations zero, one step
      send_word(KindTick, '0);
      send_word(KindTick, '1);
      send_word(KindRestart, '1);

      // skip a zero-length step, take a full pass with the largest tick
      wait_until_drained();
      program_pattern(4'd4, 8'd0, 1'b0, {16'hFFFF, 16'd0, 16'd5, 16'd3}, '0);
      send_word(KindTick, 16'd2);
      send_word(KindTick, 16'd1);
      send_word(KindTick, 16'd5);
      send_word(KindTick, '1);
      send_word(KindRestart, '1);
      send_word(KindTick, '0);

      // exponential mode, reach the cycle limit, hold, then restart
      wait_until_drained();
      program_pattern(4'd3, 8'd2, 1'b1, {16'd0, 16'd0, 16'd1, 16'd1}, '0);
      send_word(KindTick, 16'd1);
      send_word(KindTick, 16'd1);
      send_word(KindTick, 16'd2);
      send_word(KindTick, 16'd5);
      send_word(KindTick, '1);
      send_word(KindRestart, '0);
      send_word(KindTick, '0);

      // move to step 6, then shrink the pattern under it
      wait_until_drained();
      program_pattern(4'd8, 8'd0, 1'b0, {4{16'd1}}, {4{16'd1}});
      send_word(KindRestart, '0);
      send_word(KindTick, 16'd6);
      wait_until_drained();
      program_pattern(4'd3, 8'd0, 1'b0, {4{16'd1}}, {4{16'd1}});
      send_word(KindTick, '0);
      send_word(KindTick, 16'd1);

      // step count of zero and above the maximum
      wait_until_drained();
      program_pattern(4'd0, 8'd255, 1'b0, {4{16'd2}}, {4{16'd3}});
      send_word(KindTick, 16'd3);
      wait_until_drained();
      program_pattern(4'd15, 8'd255, 1'b0, {4{16'd2}}, {4{16'd3}});
      send_word(KindTick, 16'd20);

      for (p = 0; p < RandomPhases; p++) begin
         wait_until_drained();
         lo = {pick_duration(), pick_duration(), pick_duration(), pick_duration()};
         hi = {pick_duration(), pick_duration(), pick_duration(), pick_duration()};
         case (p)
            0:       program_pattern(4'd8, 8'd0, 1'($urandom), lo, hi);
            1:       program_pattern(4'd1, 8'd255, 1'($urandom), lo, hi);
            2:       program_pattern(4'd15, 8'd1, 1'($urandom), lo, hi);
            3:       program_pattern(4'd0, pick_limit(), 1'($urandom), lo, hi);
            default: program_pattern(pick_count(), pick_limit(), 1'($urandom), lo, hi);
         endcase
         // block the result side for a long stretch while words keep coming
         if (p == PressurePhase) begin
            hold_requests <= hold_requests + 1;
            burst_left = WordsPerPhase;
         end
         repeat (WordsPerPhase) begin
            if ($urandom_range(0, 11) == 0) begin
               send_word(KindRestart, DurWidth'($urandom));
            end else begin
               send_word(KindTick, pick_increment());
            end
         end
      end

      wait_until_drained();
      repeat (DrainCycles) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/lpss_pkg.sv
rtl/lpss_step_unit.sv
rtl/lpss_ctrl.sv
rtl/led_pattern_step_sequencer_top.sv
tb/led_pattern_step_sequencer_checker.sv
tb/led_pattern_step_sequencer_top_test.sv
